// ===== sv/pvt_pkg.sv =====
// Shared types and constants for the perspective vertex transform.
// Used by the MAC cells, the divider cells and the top level.
package pvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_PAIRS = 8;
    localparam int REG_IDX_W = 3;
    localparam int DIV_STEPS = 32 + FRAC_BITS;
    localparam int MAC_W     = 66;

    localparam logic [63:0] PAIR_RESET [NUM_PAIRS] = '{
        64'd1 << FRAC_BITS, 64'd0, (64'd1 << FRAC_BITS) << 32, 64'd0,
        64'd0, 64'd1 << FRAC_BITS, 64'd0, (64'd1 << FRAC_BITS) << 32
    };

    // x sits in the lowest bits, matching the stream packing
    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } vec4_t;

    // four running column sums, full product precision
    typedef struct packed {
        logic signed [MAC_W-1:0] c0;
        logic signed [MAC_W-1:0] c1;
        logic signed [MAC_W-1:0] c2;
        logic signed [MAC_W-1:0] c3;
    } acc4_t;

    // one in-flight division lane
    typedef struct packed {
        logic [DIV_STEPS-1:0] num;
        logic [DIV_STEPS-1:0] quo;
        logic [32:0]          rem;
        logic                 neg;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [2:0]    lane;
        logic [31:0]        den;
        logic signed [31:0] w_sat;
        logic               w_zero;
        logic               ovf;
    } div_beat_t;

    function automatic logic signed [31:0] sat32(input logic signed [MAC_W-1:0] v,
                                                 output logic ovf);
        if (v > $signed({{(MAC_W-32){1'b0}}, 32'h7FFFFFFF}))
        begin
            ovf = 1'b1;
            return 32'sh7FFFFFFF;
        end
        else if (v < -$signed({{(MAC_W-33){1'b0}}, 33'h080000000}))
        begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        ovf = 1'b0;
        return v[31:0];
    endfunction

endpackage

// ===== sv/perspective_vertex_transform_core.sv =====
// Perspective vertex transform: 4x4 matrix times row vector, then divide by w.
// Pipeline: 4 MAC cells, 1 saturate stage, 48 divider cells and 1 output register.
// Throughput one vertex per cycle; the whole chain stalls while the output is held.
// rst_n clears valid bits and loads the identity matrix.
// Depends on pvt_pkg, pvt_mac_cell, pvt_div_cell.
module perspective_vertex_transform_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [pvt_pkg::REG_IDX_W-1:0] cfg_idx,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // in_x, in_y, in_z, in_w
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_x, out_y, out_z, out_w
    output logic [7:0]   m_tuser    // w_zero, overflow, zero pad
);
    localparam int NS = pvt_pkg::DIV_STEPS;

    logic [63:0] pair_reg [pvt_pkg::NUM_PAIRS];
    logic        en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < pvt_pkg::NUM_PAIRS; k++)
                pair_reg[k] <= pvt_pkg::PAIR_RESET[k];
        end
        else if (cfg_we)
            pair_reg[cfg_idx] <= cfg_data;
    end

    // MAC chain
    logic           mv [5];
    pvt_pkg::vec4_t vv [5];
    pvt_pkg::acc4_t aa [5];

    assign mv[0] = s_tvalid && s_tready;
    assign vv[0] = s_tdata;
    assign aa[0] = '0;

    for (genvar r = 0; r < 4; r++)
    begin : g_mac
        pvt_mac_cell u_mac (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vld(mv[r]), .row(2'(r)), .vin(vv[r]), .ain(aa[r]),
            .mrow({pair_reg[2*r+1], pair_reg[2*r]}),
            .vld_out(mv[r+1]), .vout(vv[r+1]), .aout(aa[r+1])
        );
    end

    // floor-shift, saturate, set up division
    pvt_pkg::div_beat_t setup_next;
    logic               dv [NS+1];
    pvt_pkg::div_beat_t db [NS+1];

    always_comb
    begin
        logic signed [pvt_pkg::MAC_W-1:0] sh [4];
        logic signed [31:0]               s [4];
        logic                             o [4];
        logic [31:0]                      mag;
        sh[0] = aa[4].c0 >>> pvt_pkg::FRAC_BITS;
        sh[1] = aa[4].c1 >>> pvt_pkg::FRAC_BITS;
        sh[2] = aa[4].c2 >>> pvt_pkg::FRAC_BITS;
        sh[3] = aa[4].c3 >>> pvt_pkg::FRAC_BITS;
        for (int i = 0; i < 4; i++)
            s[i] = pvt_pkg::sat32(sh[i], o[i]);
        setup_next        = '0;
        setup_next.w_sat  = s[3];
        setup_next.w_zero = (s[3] == 32'sd0);
        setup_next.ovf    = o[0] | o[1] | o[2] | o[3];
        setup_next.den    = s[3][31] ? 32'(-s[3]) : 32'(s[3]);
        for (int i = 0; i < 3; i++)
        begin
            mag = s[i][31] ? 32'(-s[i]) : 32'(s[i]);
            setup_next.lane[i].num = {mag, {pvt_pkg::FRAC_BITS{1'b0}}};
            setup_next.lane[i].neg = s[i][31] ^ s[3][31];
        end
    end

    logic               sv_reg;
    pvt_pkg::div_beat_t sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= 1'b0;
        else if (en)
            sv_reg <= mv[4];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sb_reg <= setup_next;
    end

    assign dv[0] = sv_reg;
    assign db[0] = sb_reg;

    for (genvar j = 0; j < NS; j++)
    begin : g_div
        pvt_div_cell u_div (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vld(dv[j]), .bin(db[j]), .vld_out(dv[j+1]), .bout(db[j+1])
        );
    end

    // sign, saturate, pack
    logic [127:0] data_next;
    logic [1:0]   user_next;

    always_comb
    begin
        logic [NS-1:0]  q;
        logic           ov;
        logic [31:0]    r [3];
        ov = db[NS].ovf;
        for (int i = 0; i < 3; i++)
        begin
            q = db[NS].lane[i].quo;
            if (!db[NS].lane[i].neg)
            begin
                if (q > NS'(32'h7FFFFFFF))
                begin
                    r[i] = 32'h7FFFFFFF;
                    ov   = 1'b1;
                end
                else
                    r[i] = q[31:0];
            end
            else
            begin
                if (q > NS'(33'h080000000))
                begin
                    r[i] = 32'h80000000;
                    ov   = 1'b1;
                end
                else
                    r[i] = 32'(-q[31:0]);
            end
        end
        if (db[NS].w_zero)
        begin
            data_next = '0;
            user_next = 2'b01;
        end
        else
        begin
            data_next = {db[NS].w_sat, r[2], r[1], r[0]};
            user_next = {ov, 1'b0};
        end
    end

    logic         ov_reg;
    logic [127:0] od_reg;
    logic [1:0]   ou_reg;

    assign en = !ov_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= dv[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            od_reg <= data_next;
            ou_reg <= user_next;
        end
    end

    assign s_tready = en;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = {6'b0, ou_reg};
endmodule

// ===== sv/pvt_mac_cell.sv =====
// One multiply-accumulate cell: adds row k of the matrix times one input coordinate.
// Depends on pvt_pkg.
module pvt_mac_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vld,
    input  logic [1:0]          row,
    input  pvt_pkg::vec4_t      vin,
    input  pvt_pkg::acc4_t      ain,
    input  logic [127:0]        mrow,
    output logic                vld_out,
    output pvt_pkg::vec4_t      vout,
    output pvt_pkg::acc4_t      aout,
    input  logic                en
);
    logic signed [31:0] coord;
    logic signed [63:0] p0, p1, p2, p3;
    logic               vld_reg;
    pvt_pkg::vec4_t     v_reg;
    pvt_pkg::acc4_t     a_reg;

    function automatic logic signed [pvt_pkg::MAC_W-1:0] MAC_EXT(input logic signed [63:0] p);
        return {{(pvt_pkg::MAC_W-64){p[63]}}, p};
    endfunction

    always_comb
    begin
        unique case (row)
            2'd0: coord = vin.x;
            2'd1: coord = vin.y;
            2'd2: coord = vin.z;
            default: coord = vin.w;
        endcase
        p0 = coord * $signed(mrow[31:0]);
        p1 = coord * $signed(mrow[63:32]);
        p2 = coord * $signed(mrow[95:64]);
        p3 = coord * $signed(mrow[127:96]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= vin;
            a_reg.c0 <= ain.c0 + MAC_EXT(p0);
            a_reg.c1 <= ain.c1 + MAC_EXT(p1);
            a_reg.c2 <= ain.c2 + MAC_EXT(p2);
            a_reg.c3 <= ain.c3 + MAC_EXT(p3);
        end
    end

    assign vld_out = vld_reg;
    assign vout    = v_reg;
    assign aout    = a_reg;
endmodule

// ===== sv/pvt_div_cell.sv =====
// One restoring-division step for three lanes sharing a divisor.
// Depends on pvt_pkg.
module pvt_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                vld,
    input  pvt_pkg::div_beat_t  bin,
    output logic                vld_out,
    output pvt_pkg::div_beat_t  bout
);
    logic               vld_reg;
    pvt_pkg::div_beat_t b_reg;
    pvt_pkg::div_beat_t b_next;
    logic [33:0]        trial;

    always_comb
    begin
        b_next = bin;
        trial  = '0;
        for (int i = 0; i < 3; i++)
        begin
            trial = {bin.lane[i].rem, bin.lane[i].num[pvt_pkg::DIV_STEPS-1]}
                    - {2'b00, bin.den};
            b_next.lane[i].num = bin.lane[i].num << 1;
            if (!trial[33])
            begin
                b_next.lane[i].rem = trial[32:0];
                b_next.lane[i].quo = {bin.lane[i].quo[pvt_pkg::DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                b_next.lane[i].rem = {bin.lane[i].rem[31:0],
                                      bin.lane[i].num[pvt_pkg::DIV_STEPS-1]};
                b_next.lane[i].quo = {bin.lane[i].quo[pvt_pkg::DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            b_reg <= b_next;
    end

    assign vld_out = vld_reg;
    assign bout    = b_reg;
endmodule

// ===== sv/pvt_checker.sv =====
// Port-level checks for the perspective vertex transform core.
// Depends on perspective_vertex_transform_core.
module pvt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [7:0]   m_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat dropped");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("zero w beat not cleared");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tuser[7:2] == '0)
        else $error("tuser pad nonzero");
endmodule

bind perspective_vertex_transform_core pvt_checker u_pvt_checker (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
